### rtl/slpq_pkg.sv
// slpq_pkg: shared types and codes for the sorted-list priority queue
// used by slpq_cell and sorted_list_priority_queue_unit; no dependencies

package slpq_pkg;

	// operation codes on the opcode port
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// status codes of a result
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;	// shift right from the insert point, drop new value in
		logic rem;	// shift every entry one place toward the head
	} slpq_ctl_t;

endpackage

### rtl/sorted_list_priority_queue_unit.sv
// sorted_list_priority_queue_unit: top level of the sorted-list priority queue
// depends on slpq_pkg and slpq_cell

// Priority queue of up to DEPTH unsigned values kept in ascending order in a
// row of DEPTH cells; cell 0 always holds the smallest entry. A transaction
// is accepted at a rising edge with start high and busy low; busy is always
// low, so one transaction is taken every clock cycle. opcode 0 inserts value
// (placed after any equal entries), opcode 1 removes the smallest entry. Each
// transaction gives exactly one result, registered at the accepting edge, shown
// for a single cycle with done high: front_value (zero when empty), entry_count,
// queue_empty and status (ok, insert dropped because full, remove on empty
// ignored). The result is registered and throughput is one transaction per cycle:
// every cell compares against the incoming value in parallel and the whole
// row shifts in the same edge. The receiver cannot stall, so results must be
// captured in the done cycle. No clearing pass is needed after reset.

module sorted_list_priority_queue_unit #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             opcode,
	input  logic [31:0]      value,
	output logic             done,
	output logic [31:0]      front_value,
	output logic [CNT_W-1:0] entry_count,
	output logic             queue_empty,
	output logic [1:0]       status
);

	logic                  accept;
	logic                  is_full;
	logic                  is_empty;
	logic [DATA_WIDTH-1:0] ins_value;
	slpq_pkg::slpq_ctl_t   ctl;

	logic [CNT_W-1:0]      count_q;
	logic                  done_q;
	logic [1:0]            status_q;

	// cell chain wiring
	logic [DATA_WIDTH-1:0] cell_value [DEPTH];
	logic                  cell_goes  [DEPTH];

	// no multi-cycle work, a transaction can enter every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign is_empty  = (count_q == '0);
	// input value reduced or extended to the stored width
	assign ins_value = DATA_WIDTH'(value);

	// dropped inserts and ignored removes leave the chain untouched
	assign ctl.ins = accept && (opcode == slpq_pkg::OP_INSERT) && !is_full;
	assign ctl.rem = accept && (opcode == slpq_pkg::OP_REMOVE) && !is_empty;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_v;
			logic                  left_g;
			logic [DATA_WIDTH-1:0] right_v;

			if (gi == 0) begin : g_head
				// nothing sits before the head cell
				assign left_v = '0;
				assign left_g = 1'b0;
			end else begin : g_mid
				assign left_v = cell_value[gi-1];
				assign left_g = cell_goes[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				// tail keeps its own value on remove; it falls out of range anyway
				assign right_v = cell_value[gi];
			end else begin : g_body
				assign right_v = cell_value[gi+1];
			end

			slpq_cell #(
				.DATA_WIDTH (DATA_WIDTH)
			) u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occupied    (count_q > CNT_W'(gi)),
				.ins_value   (ins_value),
				.left_value  (left_v),
				.left_goes   (left_g),
				.right_value (right_v),
				.value       (cell_value[gi]),
				.goes        (cell_goes[gi])
			);
		end
	endgenerate

	// fill count, result strobe and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= slpq_pkg::ST_OK;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				if (opcode == slpq_pkg::OP_INSERT) begin
					status_q <= is_full ? slpq_pkg::ST_FULL : slpq_pkg::ST_OK;
				end else begin
					status_q <= is_empty ? slpq_pkg::ST_EMPTY : slpq_pkg::ST_OK;
				end
			end
		end
	end

	// the chain already holds the post-transaction state in the done cycle
	assign done        = done_q;
	assign front_value = is_empty ? 32'd0 : 32'(cell_value[0]);
	assign entry_count = count_q;
	assign queue_empty = is_empty;
	assign status      = status_q;

`ifndef SYNTHESIS
	// fill count never runs past the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	// a full drop is only reported when the queue really is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == slpq_pkg::ST_FULL) |-> is_full)
		else $error("full status with free cells");

	// an ignored remove is only reported on an empty queue
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == slpq_pkg::ST_EMPTY) |-> is_empty)
		else $error("empty status with stored entries");

	// a successful remove drops the count by exactly one
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rem |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("remove did not decrement fill count");

	// the head pair stays in ascending order
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_value[0] <= cell_value[1]))
		else $error("head entries out of order");
`endif

endmodule

### rtl/slpq_cell.sv
// slpq_cell: one storage cell of the sorted chain
// uses slpq_pkg::slpq_ctl_t; instantiated by sorted_list_priority_queue_unit

module slpq_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  slpq_pkg::slpq_ctl_t    ctl,
	input  logic                   occupied,
	input  logic [DATA_WIDTH-1:0]  ins_value,
	input  logic [DATA_WIDTH-1:0]  left_value,
	input  logic                   left_goes,
	input  logic [DATA_WIDTH-1:0]  right_value,
	output logic [DATA_WIDTH-1:0]  value,
	output logic                   goes
);

	logic [DATA_WIDTH-1:0] value_q;

	// new value belongs at or before this cell (equal entries stay ahead)
	assign goes  = !occupied || (value_q > ins_value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_goes) begin
				value_q <= left_value;
			end else if (goes) begin
				value_q <= ins_value;
			end
		end else if (ctl.rem) begin
			value_q <= right_value;
		end
	end

endmodule
